/* src/tpdj_pkg.sv */
// Shared types, constants and register codes for the touch debounce filter.
package tpdj_pkg;

  localparam int unsigned CoordBitsDefault = 12;
  localparam int unsigned JumpW            = 12;
  localparam int unsigned RunW             = 4;
  localparam int unsigned CntW             = 32;
  localparam int unsigned CfgIdxW          = 2;
  localparam int unsigned CfgDataW         = 12;

  localparam logic [JumpW-1:0] JumpLimitRst      = JumpW'(160);
  localparam logic [RunW-1:0]  PressConfirmRst   = RunW'(2);
  localparam logic [RunW-1:0]  ReleaseConfirmRst = RunW'(2);

  localparam logic [CfgIdxW-1:0] RegJumpLimit      = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegPressConfirm   = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegReleaseConfirm = CfgIdxW'(2);

  typedef struct packed {
    logic [JumpW-1:0] jump_limit;
    logic [RunW-1:0]  press_confirm;
    logic [RunW-1:0]  release_confirm;
  } cfg_t;

  typedef struct packed {
    logic            stable_down;
    logic            cand_valid;
    logic            jump_pending;
    logic [RunW-1:0] press_run;
    logic [RunW-1:0] release_run;
  } flags_t;

  typedef struct packed {
    logic [CntW-1:0] unstable;
    logic [CntW-1:0] jump;
    logic [CntW-1:0] press;
    logic [CntW-1:0] release_cnt;
  } counts_t;

endpackage

/* src/tpdj_cfg_regs.sv */
// Configuration register bank for the touch debounce filter.
module tpdj_cfg_regs import tpdj_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegJumpLimit:      cfg_d.jump_limit      = cfg_data_i[JumpW-1:0];
        RegPressConfirm:   cfg_d.press_confirm   = cfg_data_i[RunW-1:0];
        RegReleaseConfirm: cfg_d.release_confirm = cfg_data_i[RunW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.jump_limit      <= JumpLimitRst;
      cfg_q.press_confirm   <= PressConfirmRst;
      cfg_q.release_confirm <= ReleaseConfirmRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* src/tpdj_update.sv */
// Next-state logic for one touch sample: press/release debounce and jump rejection.
module tpdj_update import tpdj_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDefault
) (
  input  cfg_t                 cfg_i,
  input  logic                 touched_i,
  input  logic [CoordBits-1:0] rx_i,
  input  logic [CoordBits-1:0] ry_i,
  input  flags_t               flags_i,
  input  counts_t              counts_i,
  input  logic [CoordBits-1:0] held_x_i,
  input  logic [CoordBits-1:0] held_y_i,
  input  logic [CoordBits-1:0] cand_x_i,
  input  logic [CoordBits-1:0] cand_y_i,
  output flags_t               flags_o,
  output counts_t              counts_o,
  output logic [CoordBits-1:0] held_x_o,
  output logic [CoordBits-1:0] held_y_o,
  output logic [CoordBits-1:0] cand_x_o,
  output logic [CoordBits-1:0] cand_y_o
);

  localparam int unsigned CmpW = (CoordBits > JumpW) ? CoordBits : JumpW;
  localparam logic [RunW-1:0] RunMax = '1;

  logic [CoordBits-1:0] dhx, dhy, dcx, dcy;
  logic [CmpW-1:0]      limit;
  logic                 far_held, far_cand;
  logic [RunW-1:0]      press_inc, release_inc;

  assign dhx = (rx_i >= held_x_i) ? rx_i - held_x_i : held_x_i - rx_i;
  assign dhy = (ry_i >= held_y_i) ? ry_i - held_y_i : held_y_i - ry_i;
  assign dcx = (rx_i >= cand_x_i) ? rx_i - cand_x_i : cand_x_i - rx_i;
  assign dcy = (ry_i >= cand_y_i) ? ry_i - cand_y_i : cand_y_i - ry_i;
  assign limit = CmpW'(cfg_i.jump_limit);

  assign far_held = (CmpW'(dhx) > limit) || (CmpW'(dhy) > limit);
  assign far_cand = (CmpW'(dcx) > limit) || (CmpW'(dcy) > limit);

  assign press_inc   = (flags_i.press_run == RunMax) ? RunMax : flags_i.press_run + RunW'(1);
  assign release_inc = (flags_i.release_run == RunMax) ? RunMax
                                                       : flags_i.release_run + RunW'(1);

  always_comb begin
    flags_o  = flags_i;
    counts_o = counts_i;
    held_x_o = held_x_i;
    held_y_o = held_y_i;
    cand_x_o = cand_x_i;
    cand_y_o = cand_y_i;
    if (touched_i) begin
      flags_o.release_run = '0;
      if (flags_i.stable_down) begin
        if (far_held && !flags_i.jump_pending) begin
          flags_o.jump_pending = 1'b1;
          counts_o.jump        = counts_i.jump + CntW'(1);
        end else begin
          held_x_o             = rx_i;
          held_y_o             = ry_i;
          flags_o.jump_pending = 1'b0;
        end
      end else if (!flags_i.cand_valid) begin
        cand_x_o           = rx_i;
        cand_y_o           = ry_i;
        flags_o.cand_valid = 1'b1;
        flags_o.press_run  = RunW'(1);
        counts_o.unstable  = counts_i.unstable + CntW'(1);
      end else if (far_cand) begin
        cand_x_o          = rx_i;
        cand_y_o          = ry_i;
        flags_o.press_run = RunW'(1);
        counts_o.jump     = counts_i.jump + CntW'(1);
      end else begin
        cand_x_o          = rx_i;
        cand_y_o          = ry_i;
        flags_o.press_run = press_inc;
        if (press_inc >= cfg_i.press_confirm) begin
          flags_o.stable_down = 1'b1;
          flags_o.cand_valid  = 1'b0;
          flags_o.press_run   = '0;
          held_x_o            = rx_i;
          held_y_o            = ry_i;
          counts_o.press      = counts_i.press + CntW'(1);
        end
      end
    end else begin
      flags_o.cand_valid   = 1'b0;
      flags_o.press_run    = '0;
      flags_o.jump_pending = 1'b0;
      if (flags_i.stable_down) begin
        flags_o.release_run = release_inc;
        if (release_inc >= cfg_i.release_confirm) begin
          flags_o.stable_down  = 1'b0;
          flags_o.release_run  = '0;
          counts_o.release_cnt = counts_i.release_cnt + CntW'(1);
        end
      end else begin
        flags_o.release_run = '0;
      end
    end
  end

endmodule

/* src/touch_press_debounce_jump_filter_core.sv */
// Top level of the touch press debounce and jump rejection filter.
// Each accepted sample (touch flag and x,y) yields one item with the debounced
// pressed state, the held position and four wrapping event counters. A sample is
// latched in an input register and resolved from there into the filter state,
// which doubles as the result register; the compare and update path between
// them is combinational. One sample can be taken every cycle while the receiver
// accepts results. Configuration writes complete at once.
module touch_press_debounce_jump_filter_core import tpdj_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  touch_present_i,
  input  logic [COORD_BITS-1:0] raw_x_i,
  input  logic [COORD_BITS-1:0] raw_y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  pressed_out_o,
  output logic [COORD_BITS-1:0] pos_x_o,
  output logic [COORD_BITS-1:0] pos_y_o,
  output logic [CntW-1:0]       unstable_events_o,
  output logic [CntW-1:0]       jump_events_o,
  output logic [CntW-1:0]       press_events_o,
  output logic [CntW-1:0]       release_events_o
);

  cfg_t cfg;

  logic                  in_vld_q;
  logic                  touch_q;
  logic [COORD_BITS-1:0] rx_q, ry_q;
  logic                  out_vld_q;
  logic                  advance;

  flags_t                flags_q, flags_d;
  counts_t               counts_q, counts_d;
  logic [COORD_BITS-1:0] held_x_q, held_x_d, held_y_q, held_y_d;
  logic [COORD_BITS-1:0] cand_x_q, cand_x_d, cand_y_q, cand_y_d;

  tpdj_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tpdj_update #(
    .CoordBits (COORD_BITS)
  ) u_update (
    .cfg_i     (cfg),
    .touched_i (touch_q),
    .rx_i      (rx_q),
    .ry_i      (ry_q),
    .flags_i   (flags_q),
    .counts_i  (counts_q),
    .held_x_i  (held_x_q),
    .held_y_i  (held_y_q),
    .cand_x_i  (cand_x_q),
    .cand_y_i  (cand_y_q),
    .flags_o   (flags_d),
    .counts_o  (counts_d),
    .held_x_o  (held_x_d),
    .held_y_o  (held_y_d),
    .cand_x_o  (cand_x_d),
    .cand_y_o  (cand_y_d)
  );

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      touch_q <= touch_present_i;
      rx_q    <= raw_x_i;
      ry_q    <= raw_y_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      flags_q   <= '0;
      counts_q  <= '0;
      held_x_q  <= '0;
      held_y_q  <= '0;
      cand_x_q  <= '0;
      cand_y_q  <= '0;
    end else begin
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (advance) begin
        flags_q  <= flags_d;
        counts_q <= counts_d;
        held_x_q <= held_x_d;
        held_y_q <= held_y_d;
        cand_x_q <= cand_x_d;
        cand_y_q <= cand_y_d;
      end
    end
  end

  assign out_valid_o       = out_vld_q;
  assign pressed_out_o     = flags_q.stable_down;
  assign pos_x_o           = held_x_q;
  assign pos_y_o           = held_y_q;
  assign unstable_events_o = counts_q.unstable;
  assign jump_events_o     = counts_q.jump;
  assign press_events_o    = counts_q.press;
  assign release_events_o  = counts_q.release_cnt;

`ifndef NO_ASSERTIONS
  a_press_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(flags_q.stable_down) |-> counts_q.press == $past(counts_q.press) + CntW'(1))
    else $error("press accepted without press count");

  a_release_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(flags_q.stable_down) |-> counts_q.release_cnt == $past(counts_q.release_cnt) + CntW'(1))
    else $error("release accepted without release count");

  a_no_cand_when_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.stable_down |-> !flags_q.cand_valid)
    else $error("candidate open while pressed");

  a_no_pending_when_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !flags_q.stable_down |-> !flags_q.jump_pending)
    else $error("jump pending while released");

  a_state_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(counts_q) && $stable(flags_q))
    else $error("filter state changed without an item");
`endif

endmodule

/* sim/touch_press_debounce_jump_filter_core_tb.sv */
// Self-checking testbench for the touch press debounce and jump rejection core.
`timescale 1ns / 1ps

module touch_press_debounce_jump_filter_core_tb;
  import tpdj_pkg::*;

  localparam int unsigned CB = CoordBitsDefault;
  localparam int CoordMax = (1 << CB) - 1;
  localparam logic [CfgIdxW-1:0] RegUnused = CfgIdxW'(3);
  localparam int WatchdogLimit = 4000;
  localparam int HoldOffCycles = 200;
  localparam int MaxPrinted = 60;

  typedef struct packed {
    logic          pressed;
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    counts_t       cnt;
  } touch_report_t;

  typedef struct packed {
    logic          touch;
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          typed;
    touch_report_t want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                touch_present_i;
  logic [CB-1:0]       raw_x_i;
  logic [CB-1:0]       raw_y_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                pressed_out_o;
  logic [CB-1:0]       pos_x_o;
  logic [CB-1:0]       pos_y_o;
  logic [CntW-1:0]     unstable_events_o;
  logic [CntW-1:0]     jump_events_o;
  logic [CntW-1:0]     press_events_o;
  logic [CntW-1:0]     release_events_o;

  touch_press_debounce_jump_filter_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .touch_present_i  (touch_present_i),
    .raw_x_i          (raw_x_i),
    .raw_y_i          (raw_y_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pressed_out_o    (pressed_out_o),
    .pos_x_o          (pos_x_o),
    .pos_y_o          (pos_y_o),
    .unstable_events_o(unstable_events_o),
    .jump_events_o    (jump_events_o),
    .press_events_o   (press_events_o),
    .release_events_o (release_events_o)
  );

  // filter state mirrored by the predictor
  cfg_t          model_cfg;
  flags_t        st_flags;
  counts_t       st_counts;
  logic [CB-1:0] st_held_x, st_held_y, st_cand_x, st_cand_y;

  touch_report_t pending_reports[$];
  stim_row_t     dir_rows[$];
  int            n_mismatch = 0;
  int            n_accepted = 0;
  bit            no_idle = 1'b0;
  int            idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit far_from(logic [CB-1:0] ax, logic [CB-1:0] ay,
                                  logic [CB-1:0] bx, logic [CB-1:0] by);
    int dx, dy;
    dx = (ax >= bx) ? int'(ax) - int'(bx) : int'(bx) - int'(ax);
    dy = (ay >= by) ? int'(ay) - int'(by) : int'(by) - int'(ay);
    return (dx > int'(model_cfg.jump_limit)) || (dy > int'(model_cfg.jump_limit));
  endfunction

  function automatic logic [RunW-1:0] run_step(logic [RunW-1:0] r);
    return (r == '1) ? r : r + 1'b1;
  endfunction

  task automatic filter_sample(input logic touched, input logic [CB-1:0] rx,
                               input logic [CB-1:0] ry, output touch_report_t rep);
    if (touched) begin
      st_flags.release_run = '0;
      if (st_flags.stable_down) begin
        if (far_from(rx, ry, st_held_x, st_held_y) && !st_flags.jump_pending) begin
          st_flags.jump_pending = 1'b1;
          st_counts.jump += 1;
        end else begin
          st_held_x = rx;
          st_held_y = ry;
          st_flags.jump_pending = 1'b0;
        end
      end else if (!st_flags.cand_valid) begin
        st_cand_x = rx;
        st_cand_y = ry;
        st_flags.cand_valid = 1'b1;
        st_flags.press_run = RunW'(1);
        st_counts.unstable += 1;
      end else if (far_from(rx, ry, st_cand_x, st_cand_y)) begin
        st_cand_x = rx;
        st_cand_y = ry;
        st_flags.press_run = RunW'(1);
        st_counts.jump += 1;
      end else begin
        st_flags.press_run = run_step(st_flags.press_run);
        st_cand_x = rx;
        st_cand_y = ry;
        if (st_flags.press_run >= model_cfg.press_confirm) begin
          st_flags.stable_down = 1'b1;
          st_flags.cand_valid = 1'b0;
          st_flags.press_run = '0;
          st_held_x = rx;
          st_held_y = ry;
          st_counts.press += 1;
        end
      end
    end else begin
      st_flags.cand_valid = 1'b0;
      st_flags.press_run = '0;
      st_flags.jump_pending = 1'b0;
      if (st_flags.stable_down) begin
        st_flags.release_run = run_step(st_flags.release_run);
        if (st_flags.release_run >= model_cfg.release_confirm) begin
          st_flags.stable_down = 1'b0;
          st_flags.release_run = '0;
          st_counts.release_cnt += 1;
        end
      end else begin
        st_flags.release_run = '0;
      end
    end
    rep.pressed = st_flags.stable_down;
    rep.x = st_held_x;
    rep.y = st_held_y;
    rep.cnt = st_counts;
  endtask

  function automatic stim_row_t row_free(bit t, int x, int y);
    stim_row_t r;
    r = '0;
    r.touch = t;
    r.x = CB'(x);
    r.y = CB'(y);
    return r;
  endfunction

  function automatic stim_row_t row_want(bit t, int x, int y, bit p, int hx, int hy,
                                         int u, int j, int pr, int rl);
    stim_row_t r;
    r = row_free(t, x, y);
    r.typed = 1'b1;
    r.want.pressed = p;
    r.want.x = CB'(hx);
    r.want.y = CB'(hy);
    r.want.cnt.unstable = CntW'(u);
    r.want.cnt.jump = CntW'(j);
    r.want.cnt.press = CntW'(pr);
    r.want.cnt.release_cnt = CntW'(rl);
    return r;
  endfunction

  function automatic logic [CB-1:0] nudge(logic [CB-1:0] p, int d);
    int v;
    v = $urandom_range(1) ? int'(p) + d : int'(p) - d;
    if (v > CoordMax) v = int'(p) - d;
    if (v < 0) v = int'(p) + d;
    if (v > CoordMax) v = CoordMax;
    if (v < 0) v = 0;
    return CB'(v);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic drive_sample(input logic t, input logic [CB-1:0] x, input logic [CB-1:0] y,
                              input logic typed, input touch_report_t want);
    touch_report_t rep;
    while (!no_idle && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    touch_present_i <= t;
    raw_x_i         <= x;
    raw_y_i         <= y;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    filter_sample(t, x, y, rep);
    pending_reports.push_back(typed ? want : rep);
    n_accepted++;
    no_idle = (n_accepted >= 900) && (n_accepted < 1200);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegJumpLimit:      model_cfg.jump_limit = data[JumpW-1:0];
      RegPressConfirm:   model_cfg.press_confirm = data[RunW-1:0];
      RegReleaseConfirm: model_cfg.release_confirm = data[RunW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // touch strokes with moves near the limit, occasional jumps, lift-offs and noise
  task automatic send_gestures(input int n);
    int sent, len, k, r, d, lim, o;
    logic [CB-1:0] cx, cy;
    touch_report_t none;
    none = '0;
    sent = 0;
    while (sent < n) begin
      cx = CB'($urandom);
      cy = CB'($urandom);
      if ($urandom_range(9) == 0) begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) begin
          drive_sample(1'($urandom_range(1)), CB'($urandom), CB'($urandom), 1'b0, none);
          sent++;
        end
      end else begin
        len = $urandom_range(1, 24);
        lim = int'(model_cfg.jump_limit);
        for (k = 0; k < len; k++) begin
          r = $urandom_range(99);
          if (r < 8) d = lim + 1 + $urandom_range(0, 600);
          else if (r < 20) d = lim;
          else if (r < 24) d = lim + 1;
          else d = $urandom_range(0, lim);
          o = (d < lim) ? d : lim;
          if ($urandom_range(1)) begin
            cx = nudge(cx, d);
            cy = nudge(cy, $urandom_range(0, o));
          end else begin
            cy = nudge(cy, d);
            cx = nudge(cx, $urandom_range(0, o));
          end
          drive_sample(1'b1, cx, cy, 1'b0, none);
          sent++;
        end
        len = $urandom_range(1, 17);
        for (k = 0; k < len; k++) begin
          drive_sample(1'b0, CB'($urandom), CB'($urandom), 1'b0, none);
          sent++;
        end
      end
    end
  endtask

  task automatic run_phase(input int jl, input int pc, input int rc, input int n,
                           input bit poke_unused);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    if (poke_unused) write_reg(RegUnused, CfgDataW'($urandom));
    write_reg(RegJumpLimit, CfgDataW'(jl));
    write_reg(RegPressConfirm, {8'($urandom), 4'(pc)});
    write_reg(RegReleaseConfirm, {8'($urandom), 4'(rc)});
    cfg_valid_i <= 1'b0;
    send_gestures(n);
    in_valid_i <= 1'b0;
  endtask

  task automatic cmp_field(input string name, input longint unsigned e,
                           input longint unsigned a);
    if (e != a) begin
      n_mismatch++;
      if (n_mismatch <= MaxPrinted)
        $display("%0t: %s expected %0d, got %0d", $time, name, e, a);
    end
  endtask

  // result receiver with random stalls and one long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (!hold_done && n_accepted >= 120) begin
        hold_done = 1'b1;
        hold_left = HoldOffCycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle ? 1'b1 : ($urandom_range(99) >= 9);
      end
    end
  end

  always @(posedge clk_i) begin
    touch_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MaxPrinted)
          $display("%0t: unexpected item, expected none, got pressed %0d pos %0d,%0d",
                   $time, pressed_out_o, pos_x_o, pos_y_o);
      end else begin
        want = pending_reports.pop_front();
        cmp_field("pressed_out", want.pressed, pressed_out_o);
        cmp_field("pos_x", want.x, pos_x_o);
        cmp_field("pos_y", want.y, pos_y_o);
        cmp_field("unstable_events", want.cnt.unstable, unstable_events_o);
        cmp_field("jump_events", want.cnt.jump, jump_events_o);
        cmp_field("press_events", want.cnt.press, press_events_o);
        cmp_field("release_events", want.cnt.release_cnt, release_events_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int i;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    touch_present_i = 1'b0;
    raw_x_i         = '0;
    raw_y_i         = '0;

    model_cfg.jump_limit      = JumpLimitRst;
    model_cfg.press_confirm   = PressConfirmRst;
    model_cfg.release_confirm = ReleaseConfirmRst;
    st_flags  = '0;
    st_counts = '0;
    st_held_x = '0;
    st_held_y = '0;
    st_cand_x = '0;
    st_cand_y = '0;

    // reset config: limit 160, two samples to press, two to release
    dir_rows.push_back(row_want(0, 4095, 4095, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row_want(1, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    dir_rows.push_back(row_want(1, 160, 160, 1, 160, 160, 1, 0, 1, 0));
    dir_rows.push_back(row_want(1, 4095, 4095, 1, 160, 160, 1, 1, 1, 0));
    dir_rows.push_back(row_want(1, 4095, 4095, 1, 4095, 4095, 1, 1, 1, 0));
    dir_rows.push_back(row_want(1, 4095, 0, 1, 4095, 4095, 1, 2, 1, 0));
    dir_rows.push_back(row_want(0, 0, 0, 1, 4095, 4095, 1, 2, 1, 0));
    dir_rows.push_back(row_want(1, 4095, 3935, 1, 4095, 3935, 1, 2, 1, 0));
    dir_rows.push_back(row_want(0, 4095, 4095, 1, 4095, 3935, 1, 2, 1, 0));
    dir_rows.push_back(row_want(0, 0, 4095, 0, 4095, 3935, 1, 2, 1, 1));
    dir_rows.push_back(row_want(1, 100, 100, 0, 4095, 3935, 2, 2, 1, 1));
    // jumps during a candidate restart it without a new candidate count
    dir_rows.push_back(row_want(1, 261, 100, 0, 4095, 3935, 2, 3, 1, 1));
    dir_rows.push_back(row_want(1, 261, 261, 0, 4095, 3935, 2, 4, 1, 1));
    dir_rows.push_back(row_want(1, 300, 300, 1, 300, 300, 2, 4, 2, 1));
    dir_rows.push_back(row_free(1, 300, 300));
    dir_rows.push_back(row_free(1, 0, 4095));
    dir_rows.push_back(row_free(0, 4095, 0));
    dir_rows.push_back(row_free(1, 0, 4095));
    dir_rows.push_back(row_free(1, 4095, 4095));
    dir_rows.push_back(row_free(0, 1234, 2345));
    dir_rows.push_back(row_free(0, 0, 0));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (i = 0; i < dir_rows.size(); i++)
      drive_sample(dir_rows[i].touch, dir_rows[i].x, dir_rows[i].y,
                   dir_rows[i].typed, dir_rows[i].want);
    send_gestures(230);
    in_valid_i <= 1'b0;

    run_phase(0, 1, 1, 220, 1'b0);
    run_phase(4095, 15, 15, 220, 1'b0);
    run_phase($urandom_range(1, 400), 0, 0, 220, 1'b0);
    run_phase(160, 2, 2, 200, 1'b1);
    repeat (3)
      run_phase($urandom_range(3) ? $urandom_range(0, 300) : $urandom_range(0, CoordMax),
                $urandom_range(0, 15), $urandom_range(0, 15), 230, 1'b0);

    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (n_mismatch == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
